### rtl/gelu_activation_macros.svh
// assertion macros shared by the gelu activation rtl
// needs clk and rst_n in the scope where a macro is used
`ifndef GELU_ACTIVATION_MACROS_SVH
`define GELU_ACTIVATION_MACROS_SVH

// same-cycle implication, off while in reset
`define GA_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define GA_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gelu_pkg.sv
// package for the gelu activation block: transfer types and constants
// no dependencies
package gelu_pkg;

    localparam int X_W              = 16;
    localparam int TANH_W           = 15;
    localparam int POS_W            = 26;
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int FRAC_BITS_DEF    = 12;

    // q0.16 constants and their q0.32 product
    localparam logic [15:0] C_SQRT2PI = 16'd52290;
    localparam logic [11:0] C_CUBIC   = 12'd2930;
    localparam logic [27:0] C_INNER   = 28'(C_SQRT2PI * C_CUBIC);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [TANH_W-1:0] TANH_MAX = {TANH_W{1'b1}};

    // tanh table generation
    localparam logic [63:0] Q31_ONE  = 64'h0000_0000_8000_0000;
    localparam logic [63:0] EXP_STEP = 64'd2114190000;

    typedef struct packed {
        logic signed [X_W-1:0] x_value;
        logic                  last_in;
    } gelu_in_t;

    typedef struct packed {
        logic signed [X_W-1:0] y_value;
        logic                  last_out;
    } gelu_out_t;

endpackage

### rtl/gelu_activation.sv
// gelu activation, tanh form, signed fixed point, fully pipelined
// depends on gelu_pkg and gelu_activation_macros.svh
//
//   channel   strobe   payload   direction
//   item      start    x_value   in, taken when start high and busy low
//             busy     last_in
//   result    done     y_value   out, held for one cycle only
//                      last_out
//
// one item per cycle; done and the result leave the last of the ten register stages
// (cube and inner products, tanh table read, interpolation, final product,
// rounding); the tanh table is a two-port rom with registered read data.
// busy stays low: nothing holds the pipeline, results cannot be stalled.
// reset clears the stage valid bits and done only, no clearing pass.
`include "gelu_activation_macros.svh"

module gelu_activation
    import gelu_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  gelu_in_t  item,
    output logic      done,
    output gelu_out_t result
);

    localparam int STAGES  = 9;
    localparam int LATENCY = STAGES + 1;
    localparam int AW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IDX_W   = (AW > 10) ? AW : 10;
    localparam int SPLIT   = 23;
    localparam int A3_W    = 46;
    localparam int KH_W    = 28 + A3_W - SPLIT;
    localparam int KL_W    = 28 + SPLIT;
    localparam int Y_W     = 73;
    localparam int M_SH    = 2 * FRAC_BITS + 16;
    localparam int YQ_W    = Y_W - M_SH;
    localparam int SUM_W   = ((YQ_W > 32) ? YQ_W : 32) + 1;
    localparam int P_SH    = FRAC_BITS - 7;

    typedef logic [TANH_W-1:0] rom_t [TABLE_ENTRIES];

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [16:0] q;
        e = Q31_ONE;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            num = ((Q31_ONE - e) << 16) + (Q31_ONE + e);
            den = (Q31_ONE + e) << 1;
            rem = num;
            q   = '0;
            for (int b = 16; b >= 0; b--)
            begin
                if (rem >= (den << b))
                begin
                    rem  = rem - (den << b);
                    q[b] = 1'b1;
                end
            end
            rom[k] = (q > 17'(TANH_MAX)) ? TANH_MAX : q[TANH_W-1:0];
            e = (e * EXP_STEP + (64'd1 << 30)) >> 31;
        end
        return rom;
    endfunction

    localparam rom_t TANH_ROM = build_rom();

    // stage valid bits and pass-along payload
    logic [STAGES-1:0]            valid_reg;
    logic signed [X_W-1:0]        x_reg    [STAGES-1];
    logic                         last_reg [STAGES];
    logic                         accept;

    // stage payload
    logic [15:0]                  ax_reg, ax2_reg;
    logic [15:0]                  ax_next;
    logic [31:0]                  sq_reg, p1_reg, p1_3_reg, p1_4_reg, p1_5_reg;
    logic [A3_W-1:0]              a3_reg;
    logic [KH_W-1:0]              kh_reg;
    logic [KL_W-1:0]              kl_reg;
    logic [Y_W-1:0]               y_full;
    logic [YQ_W-1:0]              yq_reg;
    logic [SUM_W-1:0]             pos_sum, pos_shift;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [IDX_W-1:0]             idx_ext, idx_inc;
    logic                         tab_sat;
    logic [AW-1:0]                addr_a, addr_b;
    logic [TANH_W-1:0]            rom_a_reg, rom_b_reg;
    logic [15:0]                  frac_reg, frac_next;
    logic [TANH_W-1:0]            diff;
    logic [31:0]                  interp;
    logic [TANH_W-1:0]            mag_reg, mag_next;
    logic [15:0]                  factor;
    logic signed [32:0]           prod_full;
    logic signed [31:0]           p_reg;
    logic signed [32:0]           q_round;
    logic signed [16:0]           y_wide;
    logic signed [X_W-1:0]        y_next;

    logic                         done_reg;
    gelu_out_t                    result_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        ax_next = item.x_value[X_W-1] ? 16'(-item.x_value) : 16'(item.x_value);

        y_full  = Y_W'({kh_reg, SPLIT'(0)}) + Y_W'(kl_reg);

        pos_sum   = SUM_W'(p1_5_reg) + SUM_W'(yq_reg);
        pos_shift = pos_sum >> P_SH;
        pos_next  = (pos_shift > SUM_W'(POS_MAX)) ? POS_MAX : pos_shift[POS_W-1:0];

        // past the last entry: flat, no interpolation
        idx_ext   = IDX_W'(pos_reg[POS_W-1:16]);
        idx_inc   = idx_ext + IDX_W'(1);
        tab_sat   = (idx_ext >= IDX_W'(TABLE_ENTRIES - 1));
        addr_a    = tab_sat ? AW'(TABLE_ENTRIES - 1) : idx_ext[AW-1:0];
        addr_b    = tab_sat ? AW'(TABLE_ENTRIES - 1) : idx_inc[AW-1:0];
        frac_next = tab_sat ? 16'd0 : pos_reg[15:0];

        diff     = rom_b_reg - rom_a_reg;
        interp   = 32'(diff * frac_reg) + 32'd32768;
        mag_next = rom_a_reg + interp[16+TANH_W-1:16];

        // odd symmetry: 1 + tanh or 1 - tanh in q1.15
        factor    = x_reg[STAGES-2][X_W-1] ? 16'(17'd32768 - 17'(mag_reg))
                                           : 16'(17'd32768 + 17'(mag_reg));
        prod_full = x_reg[STAGES-2] * $signed({1'b0, factor});

        q_round = 33'(p_reg) + 33'sd32768;
        y_wide  = q_round[32:16];
        if (y_wide > 17'sd32767)
            y_next = 16'sh7FFF;
        else if (y_wide < -17'sd32768)
            y_next = 16'sh8000;
        else
            y_next = y_wide[X_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], accept};
            done_reg  <= valid_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= item.x_value;
        last_reg[0] <= item.last_in;
        for (int s = 1; s < STAGES - 1; s++)
            x_reg[s] <= x_reg[s-1];
        for (int s = 1; s < STAGES; s++)
            last_reg[s] <= last_reg[s-1];

        ax_reg    <= ax_next;
        sq_reg    <= 32'(ax_reg * ax_reg);
        p1_reg    <= 32'(C_SQRT2PI * ax_reg);
        ax2_reg   <= ax_reg;
        a3_reg    <= A3_W'(sq_reg * ax2_reg);
        p1_3_reg  <= p1_reg;
        kl_reg    <= KL_W'(C_INNER * a3_reg[SPLIT-1:0]);
        kh_reg    <= KH_W'(C_INNER * a3_reg[A3_W-1:SPLIT]);
        p1_4_reg  <= p1_3_reg;
        yq_reg    <= y_full[Y_W-1:M_SH];
        p1_5_reg  <= p1_4_reg;
        pos_reg   <= pos_next;
        rom_a_reg <= TANH_ROM[addr_a];
        rom_b_reg <= TANH_ROM[addr_b];
        frac_reg  <= frac_next;
        mag_reg   <= mag_next;
        p_reg     <= prod_full[31:0];

        result_reg.y_value  <= y_next;
        result_reg.last_out <= last_reg[STAGES-1];
    end

    assign done   = done_reg;
    assign result = result_reg;

    `GA_IMPLIES(a_latency, done, $past(accept, LATENCY),
                "result strobe without a transfer ten cycles back")
    `GA_IMPLIES(a_last_pass, done, result.last_out == $past(item.last_in, LATENCY),
                "last flag not carried with its element")
    `GA_IMPLIES(a_zero_in, done && $past(accept && item.x_value == 0, LATENCY),
                result.y_value == 0, "zero input gave a nonzero result")
    `GA_IMPLIES(a_neg_sign, done && $past(accept && item.x_value[X_W-1], LATENCY),
                result.y_value[X_W-1] || result.y_value == 0,
                "negative input gave a positive result")
    `GA_NEXT(a_interp_span, valid_reg[6],
             mag_reg >= $past(rom_a_reg) && mag_reg <= $past(rom_b_reg),
             "interpolated tanh outside its table interval")

endmodule

### tb/tb.sv
// testbench for gelu_activation: directed and random elements checked against an
// internal fixed-point gelu predictor with its own tanh table
// depends on gelu_pkg and the gelu_activation rtl
module tb;
    import gelu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TANH_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int          FRAC         = FRAC_BITS_DEF;
    localparam int          INNER_SHIFT  = 3 * FRAC + 9 - 32;
    localparam longint      POS_LIMIT    = (longint'(8) << 23) - 1;
    localparam longint      Q31          = longint'(1) << 31;
    localparam longint      DECAY        = 64'd2114190000;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          TAIL_CYCLES  = 16;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    gelu_in_t  item;
    logic      done;
    gelu_out_t result;

    logic [15:0] tanh_table [TANH_ENTRIES];
    gelu_out_t   expected_gelu_q [$];
    gelu_out_t   want;
    int          cycle_count = 0;
    int          transfers_sent = 0;
    int          results_checked = 0;
    int          mismatches = 0;

    gelu_activation dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic void fill_tanh_table();
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        longint unsigned v;
        e = Q31;
        for (int k = 0; k < TANH_ENTRIES; k++)
        begin
            num = ((Q31 - e) << 16) + (Q31 + e);
            den = 2 * (Q31 + e);
            v = num / den;
            if (v > 32767)
                v = 32767;
            tanh_table[k] = v[15:0];
            e = (e * DECAY + (longint'(1) << 30)) >> 31;
        end
    endfunction

    function automatic gelu_out_t predict_gelu(gelu_in_t in);
        longint          x;
        longint unsigned ax;
        longint unsigned t;
        longint unsigned th;
        longint unsigned tl;
        longint unsigned hi;
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned frac;
        longint unsigned diff64;
        int unsigned     a;
        int unsigned     b;
        int unsigned     diff;
        int unsigned     mag;
        longint          tv;
        longint          q;
        longint          y;
        gelu_out_t       r;
        x = longint'($signed(in.x_value));
        ax = (x < 0) ? longint'(-x) : longint'(x);
        t = ax * ((longint'(1) << (2 * FRAC + 16)) + longint'(C_SQRT2PI * 0 + 2930) * ax * ax);
        th = t >> 32;
        tl = t & 64'hFFFF_FFFF;
        hi = 64'd52290 * th + ((64'd52290 * tl) >> 32);
        pos = hi >> INNER_SHIFT;
        if (pos > POS_LIMIT)
            pos = POS_LIMIT;
        idx = pos >> 16;
        frac = pos & 64'hFFFF;
        if (idx >= TANH_ENTRIES - 1)
            mag = tanh_table[TANH_ENTRIES - 1];
        else
        begin
            a = tanh_table[idx];
            b = tanh_table[idx + 1];
            diff = b - a;
            diff64 = diff;
            mag = a + 32'((diff64 * frac + 32768) >> 16);
        end
        tv = mag;
        if (x < 0)
            tv = -tv;
        q = x * (32768 + tv) + 32768;
        y = q >>> 16;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        r.y_value = y[15:0];
        r.last_out = in.last_in;
        return r;
    endfunction

    // expectations are queued when a transfer is taken, results checked in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_gelu_q.push_back(predict_gelu(item));
            if (done)
            begin
                if (expected_gelu_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, actual y=%0d last=%0b",
                             $time, $signed(result.y_value), result.last_out);
                end
                else
                begin
                    want = expected_gelu_q.pop_front();
                    results_checked++;
                    if (result.y_value !== want.y_value)
                    begin
                        mismatches++;
                        $display("%0t y_value mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.y_value), $signed(result.y_value));
                    end
                    if (result.last_out !== want.last_out)
                    begin
                        mismatches++;
                        $display("%0t last_out mismatch: expected %0b, actual %0b",
                                 $time, want.last_out, result.last_out);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_gelu_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_element(input logic [15:0] x, input logic last, input int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item.x_value <= x;
        item.last_in <= last;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        transfers_sent++;
    endtask

    function automatic logic [15:0] random_activation();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return 16'($urandom);
        else if (pick < 8)
            return 16'($signed($urandom_range(0, 2 * 24576)) - 24576);
        else
            return 16'($signed($urandom_range(0, 512)) - 256);
    endfunction

    task automatic test_directed();
        logic [15:0] vals [20];
        vals = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001, 16'h7FFE,
                 16'h1000, 16'hF000, 16'h0800, 16'hF800, 16'h3000, 16'hD000,
                 16'h4800, 16'hB800, 16'h5000, 16'hB000, 16'h0010, 16'hFFF0, 16'h2AAA};
        foreach (vals[i])
            send_element(vals[i], 1'(i % 2), 0);
    endtask

    task automatic test_random_stream(input int count, input int idle_pct);
        for (int i = 0; i < count; i++)
            send_element(random_activation(), 1'($urandom_range(1)), idle_pct);
    endtask

    task automatic test_drain_pause();
        start <= 1'b0;
        while (expected_gelu_q.size() != 0)
            @(posedge clk);
        test_random_stream(300, 0);
    endtask

    initial
    begin
        fill_tanh_table();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_stream(500, 0);
        test_random_stream(400, 79);
        test_random_stream(400, 34);
        test_drain_pause();

        start <= 1'b0;
        while (expected_gelu_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d transfers: directed extremes, back-to-back, sparse and mixed gaps",
                 transfers_sent);
        $display("%0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_gelu_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
